// File: sv/jsfe_pkg.sv
// ----------------------------------------------------------------------------
// JSON string field extractor package
// Shared types, character constants, status and register codes.
// ----------------------------------------------------------------------------
package jsfe_pkg;

   // Default sizes handed to the top level.
   localparam int MAX_KEY_BYTES = 8;
   localparam int QUEUE_DEPTH   = 4;

   // Fixed field widths.
   localparam int KEY_W    = 64;
   localparam int KLEN_W   = 4;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;

   // Configuration register indexes.
   localparam logic CSR_KEY_BYTES  = 1'b0;
   localparam logic CSR_KEY_LENGTH = 1'b1;

   // Character constants.
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
   localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

   // Outcome codes carried with the final word of a result.
   localparam logic [STATUS_W-1:0] ST_CLOSED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OPEN_END   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_KEY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_COLON   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_STRING = 3'd4;

   // One classified input byte as it travels through the queue.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] esc_data;
      logic              last;
      logic              is_quote;
      logic              is_colon;
      logic              is_blank;
      logic              is_bslash;
   } item_type;

   // One result word.
   typedef struct packed {
      logic [BYTE_W-1:0]   data;
      logic                byte_valid;
      logic                value_end;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// File: sv/jsfe_front.sv
// ----------------------------------------------------------------------------
// JSON extractor front end
// Accepts text bytes and classifies each one before it enters the queue.
// ----------------------------------------------------------------------------
module jsfe_front (
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [jsfe_pkg::BYTE_W-1:0]  req_tdata,
   input  logic                         req_tlast,
   input  logic                         queue_full,
   output logic                         push,
   output jsfe_pkg::item_type           push_item
);

   // A word is taken whenever the queue has room.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Character classes and the escape translation.
   always_comb begin
      push_item.data      = req_tdata;
      push_item.last      = req_tlast;
      push_item.is_quote  = (req_tdata == jsfe_pkg::CH_QUOTE);
      push_item.is_colon  = (req_tdata == jsfe_pkg::CH_COLON);
      push_item.is_blank  = (req_tdata == jsfe_pkg::CH_SPACE) ||
                            (req_tdata == jsfe_pkg::CH_TAB);
      push_item.is_bslash = (req_tdata == jsfe_pkg::CH_BSLASH);
      if (req_tdata == jsfe_pkg::CH_LOW_N) begin
         push_item.esc_data = jsfe_pkg::CH_LF;
      end else if (req_tdata == jsfe_pkg::CH_LOW_T) begin
         push_item.esc_data = jsfe_pkg::CH_TAB;
      end else if (req_tdata == jsfe_pkg::CH_LOW_R) begin
         push_item.esc_data = jsfe_pkg::CH_CR;
      end else begin
         push_item.esc_data = req_tdata;
      end
   end

endmodule

// File: sv/jsfe_queue.sv
// ----------------------------------------------------------------------------
// JSON extractor item queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module jsfe_queue #(
   parameter int DEPTH = jsfe_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jsfe_pkg::item_type push_item,
   input  logic               pop,
   output jsfe_pkg::item_type head_item,
   output logic               full,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   jsfe_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: sv/jsfe_back.sv
// ----------------------------------------------------------------------------
// JSON extractor back end
// Runs the key search and value decoder and holds the result register.
// ----------------------------------------------------------------------------
module jsfe_back #(
   parameter int MAX_KEY_BYTES = jsfe_pkg::MAX_KEY_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [jsfe_pkg::KEY_W-1:0]    key_bytes,
   input  logic [jsfe_pkg::KLEN_W-1:0]   key_length,
   input  logic                          queue_empty,
   input  jsfe_pkg::item_type            head_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output jsfe_pkg::result_type          rsp_word
);

   localparam logic [2:0] PH_KEY   = 3'd0;
   localparam logic [2:0] PH_COLON = 3'd1;
   localparam logic [2:0] PH_SPACE = 3'd2;
   localparam logic [2:0] PH_VALUE = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   localparam logic [jsfe_pkg::KLEN_W-1:0] KEY_MAX = jsfe_pkg::KLEN_W'(MAX_KEY_BYTES);

   logic [2:0]                    phase_ff, phase_in;
   logic [jsfe_pkg::KLEN_W-1:0]   matched_ff, matched_in;
   logic                          esc_ff, esc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   jsfe_pkg::result_type          rsp_word_ff, rsp_word_in;

   logic [jsfe_pkg::KLEN_W-1:0]   key_len_eff;
   logic [jsfe_pkg::KLEN_W-1:0]   key_close;
   logic [jsfe_pkg::KLEN_W-1:0]   key_pos;
   logic [jsfe_pkg::BYTE_W-1:0]   marker;
   logic                          emit;
   jsfe_pkg::result_type          result;

   // An item moves on when the result register is free or draining.
   assign pop       = !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Expected marker byte: a quote, the key bytes, then the closing quote.
   always_comb begin
      key_len_eff = (key_length > KEY_MAX) ? KEY_MAX : key_length;
      key_close   = key_len_eff + 1'b1;
      key_pos     = matched_ff - 1'b1;
      if (matched_ff == '0 || matched_ff >= key_close) begin
         marker = jsfe_pkg::CH_QUOTE;
      end else begin
         marker = key_bytes[{key_pos[2:0], 3'b000} +: jsfe_pkg::BYTE_W];
      end
   end

   // Phase sequencer and result formation for the head item.
   always_comb begin
      phase_in   = phase_ff;
      matched_in = matched_ff;
      esc_in     = esc_ff;
      emit       = 1'b0;
      result     = '0;
      unique case (phase_ff)
         PH_KEY: begin
            if (head_item.data == marker) begin
               if (matched_ff >= key_close) begin
                  phase_in   = PH_COLON;
                  matched_in = '0;
               end else begin
                  matched_in = matched_ff + 1'b1;
               end
            end else begin
               matched_in = head_item.is_quote ? 4'd1 : 4'd0;
            end
            if (head_item.last) begin
               emit             = 1'b1;
               result.value_end = 1'b1;
               result.status    = (phase_in == PH_KEY) ? jsfe_pkg::ST_NO_KEY
                                                       : jsfe_pkg::ST_NO_COLON;
            end
         end
         PH_COLON: begin
            if (head_item.is_colon) begin
               phase_in = PH_SPACE;
            end
            if (head_item.last) begin
               emit             = 1'b1;
               result.value_end = 1'b1;
               result.status    = head_item.is_colon ? jsfe_pkg::ST_NOT_STRING
                                                     : jsfe_pkg::ST_NO_COLON;
            end
         end
         PH_SPACE: begin
            if (head_item.is_blank) begin
               if (head_item.last) begin
                  emit             = 1'b1;
                  result.value_end = 1'b1;
                  result.status    = jsfe_pkg::ST_NOT_STRING;
               end
            end else if (head_item.is_quote) begin
               phase_in = PH_VALUE;
               esc_in   = 1'b0;
               if (head_item.last) begin
                  emit             = 1'b1;
                  result.value_end = 1'b1;
                  result.status    = jsfe_pkg::ST_OPEN_END;
               end
            end else begin
               phase_in         = PH_DONE;
               emit             = 1'b1;
               result.value_end = 1'b1;
               result.status    = jsfe_pkg::ST_NOT_STRING;
            end
         end
         PH_VALUE: begin
            if (esc_ff) begin
               esc_in            = 1'b0;
               emit              = 1'b1;
               result.data       = head_item.esc_data;
               result.byte_valid = 1'b1;
               result.value_end  = head_item.last;
               result.status     = head_item.last ? jsfe_pkg::ST_OPEN_END
                                                  : jsfe_pkg::ST_CLOSED;
            end else if (head_item.is_quote) begin
               phase_in         = PH_DONE;
               emit             = 1'b1;
               result.value_end = 1'b1;
               result.status    = jsfe_pkg::ST_CLOSED;
            end else if (head_item.is_bslash && !head_item.last) begin
               esc_in = 1'b1;
            end else begin
               emit              = 1'b1;
               result.data       = head_item.data;
               result.byte_valid = 1'b1;
               result.value_end  = head_item.last;
               result.status     = head_item.last ? jsfe_pkg::ST_OPEN_END
                                                  : jsfe_pkg::ST_CLOSED;
            end
         end
         default: begin
            // Outcome already sent: bytes are dropped until the text ends.
         end
      endcase
      // The end of a text returns the parser to its starting state.
      if (head_item.last) begin
         phase_in   = PH_KEY;
         matched_in = '0;
         esc_in     = 1'b0;
      end
   end

   // Result register valid flag and payload.
   always_comb begin
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_word_in = (pop && emit) ? result : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_KEY;
         matched_ff   <= '0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff   <= phase_in;
            matched_ff <= matched_in;
            esc_ff     <= esc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: sv/json_string_field_extractor_unit.sv
// A text byte passes through a queue entry and then the result register on its way out.
// Throughput: one text byte per cycle while the result register is free or draining.
// A result word waiting on rsp_tready stalls the back end; the queue absorbs up to
// QUEUE_DEPTH further bytes before req_tready drops.
// Reset (synchronous, active high) clears the parser, the queue and both key registers.
// ----------------------------------------------------------------------------
// JSON string field extractor
// Finds a quoted key in a JSON text and streams out its decoded string value.
// ----------------------------------------------------------------------------
module json_string_field_extractor_unit #(
   parameter int MAX_KEY_BYTES = jsfe_pkg::MAX_KEY_BYTES,
   parameter int QUEUE_DEPTH   = jsfe_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration write port.
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [jsfe_pkg::KEY_W-1:0]  csr_wdata,
   // Text input: tdata[7:0] in_byte; tlast in_last.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   input  logic                        req_tlast,
   // Results: tdata[7:0] out_byte, tdata[10:8] status, rest zero;
   // tuser[0] byte_valid; tlast value_end.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   logic [jsfe_pkg::KEY_W-1:0]  key_bytes_ff, key_bytes_in;
   logic [jsfe_pkg::KLEN_W-1:0] key_length_ff, key_length_in;

   logic                 queue_full;
   logic                 queue_empty;
   logic                 push;
   logic                 pop;
   jsfe_pkg::item_type   push_item;
   jsfe_pkg::item_type   head_item;
   jsfe_pkg::result_type rsp_word;

   // Key registers.
   always_comb begin
      key_bytes_in  = key_bytes_ff;
      key_length_in = key_length_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            jsfe_pkg::CSR_KEY_BYTES:  key_bytes_in  = csr_wdata;
            jsfe_pkg::CSR_KEY_LENGTH: key_length_in = csr_wdata[jsfe_pkg::KLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff  <= '0;
         key_length_ff <= '0;
      end else begin
         key_bytes_ff  <= key_bytes_in;
         key_length_ff <= key_length_in;
      end
   end

   jsfe_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   jsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   jsfe_back #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .key_bytes   (key_bytes_ff),
      .key_length  (key_length_ff),
      .queue_empty (queue_empty),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_word    (rsp_word)
   );

   // Result word packing.
   assign rsp_tdata = {5'b00000, rsp_word.status, rsp_word.data};
   assign rsp_tuser = rsp_word.byte_valid;
   assign rsp_tlast = rsp_word.value_end;

endmodule

// File: sv/jsfe_checker.sv
// ----------------------------------------------------------------------------
// JSON extractor port checker
// Watches the top-level ports for result-word rules of this block.
// ----------------------------------------------------------------------------
module jsfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // No result word is offered right after reset.
   assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result word offered right after reset");

   // A stalled result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // A word that does not end the result always carries a value byte with status zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser && (rsp_tdata[10:8] == 3'd0))
      else $error("intermediate result word without a value byte");

   // A word without a value byte has a zero byte field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[7:0] == 8'h00))
      else $error("nonzero byte field without byte_valid");

   // Status stays within the defined codes and the pad bits stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:8] <= 3'd4) && (rsp_tdata[15:11] == 5'd0))
      else $error("result status or padding out of range");

endmodule

bind json_string_field_extractor_unit jsfe_checker u_jsfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
